/* rtl/tse_pkg.sv */
package tse_pkg;

	localparam int COLUMN_BITS = 16;
	localparam int MAX_STOPS   = 7;
	localparam int CHAR_BITS   = 8;
	localparam int COUNT_BITS  = 8;
	localparam int STOP_BITS   = 8;
	localparam int INDEX_BITS  = 3;
	localparam int CFG_BITS    = 8;

	localparam logic [CHAR_BITS-1:0] CHAR_TAB     = 8'd9;
	localparam logic [CHAR_BITS-1:0] CHAR_NEWLINE = 8'd10;
	localparam logic [CHAR_BITS-1:0] CHAR_SPACE   = 8'd32;

	localparam logic [COUNT_BITS-1:0] RUN_MAX = 8'd255;

	localparam logic [INDEX_BITS-1:0] REG_STOP_COUNT = 3'd0;

	localparam logic [INDEX_BITS-1:0] STOP_COUNT_RESET = 3'd1;
	localparam logic [STOP_BITS-1:0]  STOP0_RESET      = 8'd8;

	typedef logic [COLUMN_BITS-1:0] col_t;
	typedef logic [INDEX_BITS-1:0]  idx_t;

	typedef struct packed {
		idx_t                                 stop_count;
		logic [MAX_STOPS-1:0][STOP_BITS-1:0]  stops;
	} cfg_t;

	typedef struct packed {
		col_t column;
		idx_t stop_index;
		col_t next_stop;
	} state_t;

	typedef struct packed {
		logic                  has_result;
		logic [CHAR_BITS-1:0]  out_char;
		logic [COUNT_BITS-1:0] out_count;
	} result_t;

	function automatic col_t sat_add(input col_t a, input col_t b);
		logic [COLUMN_BITS:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[COLUMN_BITS] ? {COLUMN_BITS{1'b1}} : s[COLUMN_BITS-1:0];
	endfunction

	function automatic col_t stop_val(input cfg_t cfg, input idx_t i);
		col_t v;
		v = '0;
		if (i < idx_t'(MAX_STOPS)) begin
			v = col_t'(cfg.stops[i]);
		end
		return v;
	endfunction

endpackage

/* rtl/tse_if.sv */
interface tse_in_if;
	logic                             valid;
	logic                             ready;
	logic [tse_pkg::CHAR_BITS-1:0]    in_char;
	logic                             file_start;

	modport source (output valid, output in_char, output file_start, input ready);
	modport sink (input valid, input in_char, input file_start, output ready);
endinterface

interface tse_out_if;
	logic                             valid;
	logic                             ready;
	logic [tse_pkg::CHAR_BITS-1:0]    out_char;
	logic [tse_pkg::COUNT_BITS-1:0]   out_count;

	modport source (output valid, output out_char, output out_count, input ready);
	modport sink (input valid, input out_char, input out_count, output ready);
endinterface

/* rtl/tab_stop_expander_core.sv */
// Tab stop expander: each transfer on in_ch carries one text byte; the block answers
// with at most one transfer on out_ch, a byte and a repeat count (a tab becomes a run
// of spaces up to the next stop; a tab whose next stop, after any advance, is not
// past its column gives nothing). One byte is taken per cycle unless out_ch stalls;
// each byte passes an input register and a result register, with the column and stop
// update done in one step between them. The user must write stop registers through
// cfg_we/cfg_index/cfg_data only while the stream is idle, unchecked by the block.
module tab_stop_expander_core (
	input  logic                              clk,
	input  logic                              arst_n,
	tse_in_if.sink                            in_ch,
	tse_out_if.source                         out_ch,
	input  logic                              cfg_we,
	input  tse_pkg::idx_t                     cfg_index,
	input  logic [tse_pkg::CFG_BITS-1:0]      cfg_data
);

	tse_pkg::cfg_t    cfg;
	tse_pkg::state_t  state_q;
	tse_pkg::state_t  state_nxt;
	tse_pkg::result_t result;

	logic                            valid_s1;
	logic [tse_pkg::CHAR_BITS-1:0]   in_char_s1;
	logic                            file_start_s1;
	logic                            valid_s2;
	logic [tse_pkg::CHAR_BITS-1:0]   out_char_s2;
	logic [tse_pkg::COUNT_BITS-1:0]  out_count_s2;
	logic                            advance_s1;

	tse_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	tse_step u_step (
		.cfg        (cfg),
		.state_cur  (state_q),
		.in_char    (in_char_s1),
		.file_start (file_start_s1),
		.state_nxt  (state_nxt),
		.result     (result)
	);

	assign advance_s1  = valid_s1 && (!valid_s2 || out_ch.ready);
	assign in_ch.ready = !valid_s1 || advance_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			in_char_s1    <= in_ch.in_char;
			file_start_s1 <= in_ch.file_start;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{column: '0, stop_index: '0,
				next_stop: tse_pkg::col_t'(tse_pkg::STOP0_RESET)};
		end else if (advance_s1) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance_s1) begin
			valid_s2 <= result.has_result;
		end else if (out_ch.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1 && result.has_result) begin
			out_char_s2  <= result.out_char;
			out_count_s2 <= result.out_count;
		end
	end

	assign out_ch.valid     = valid_s2;
	assign out_ch.out_char  = out_char_s2;
	assign out_ch.out_count = out_count_s2;

	a_stall_holds_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && valid_s2 && !out_ch.ready |=> valid_s1 && $stable(in_char_s1))
		else $error("stalled item left the input register");

	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> out_count_s2 != '0)
		else $error("result with zero count");

	a_newline_restart: assert property (@(posedge clk) disable iff (!arst_n)
		advance_s1 && in_char_s1 == tse_pkg::CHAR_NEWLINE
		|=> state_q.column == '0 && state_q.stop_index == '0)
		else $error("newline did not restart the line");

	a_state_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		!advance_s1 |=> $stable(state_q))
		else $error("line state moved without a retiring item");

endmodule

/* rtl/tse_cfg_regs.sv */
module tse_cfg_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  tse_pkg::idx_t                     cfg_index,
	input  logic [tse_pkg::CFG_BITS-1:0]      cfg_data,
	output tse_pkg::cfg_t                     cfg
);

	tse_pkg::cfg_t cfg_q;
	tse_pkg::idx_t stop_sel;

	assign stop_sel = cfg_index - tse_pkg::idx_t'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= {tse_pkg::STOP_COUNT_RESET,
				{((tse_pkg::MAX_STOPS-1)*tse_pkg::STOP_BITS){1'b0}},
				tse_pkg::STOP0_RESET};
		end else if (cfg_we) begin
			if (cfg_index == tse_pkg::REG_STOP_COUNT) begin
				cfg_q.stop_count <= cfg_data[tse_pkg::INDEX_BITS-1:0];
			end else if (stop_sel < tse_pkg::idx_t'(tse_pkg::MAX_STOPS)) begin
				cfg_q.stops[stop_sel] <= cfg_data[tse_pkg::STOP_BITS-1:0];
			end
		end
	end

	assign cfg = cfg_q;

endmodule

/* rtl/tse_step.sv */
module tse_step (
	input  tse_pkg::cfg_t                   cfg,
	input  tse_pkg::state_t                 state_cur,
	input  logic [tse_pkg::CHAR_BITS-1:0]   in_char,
	input  logic                            file_start,
	output tse_pkg::state_t                 state_nxt,
	output tse_pkg::result_t                result
);

	tse_pkg::state_t restart_st;
	tse_pkg::state_t base;
	tse_pkg::state_t adv;
	tse_pkg::idx_t   eff_count;
	tse_pkg::idx_t   idx_inc;
	tse_pkg::col_t   run_full;
	logic [tse_pkg::COUNT_BITS-1:0] run;

	always_comb begin
		eff_count = cfg.stop_count;
		if (eff_count == '0) begin
			eff_count = tse_pkg::idx_t'(1);
		end
		if (eff_count > tse_pkg::idx_t'(tse_pkg::MAX_STOPS)) begin
			eff_count = tse_pkg::idx_t'(tse_pkg::MAX_STOPS);
		end

		restart_st.column     = '0;
		restart_st.stop_index = '0;
		restart_st.next_stop  = tse_pkg::stop_val(cfg, '0);

		base = file_start ? restart_st : state_cur;

		// stop advance before the byte
		adv     = base;
		idx_inc = base.stop_index + tse_pkg::idx_t'(1);
		if (base.column >= base.next_stop) begin
			priority if ({1'b0, base.stop_index} + 4'd1 < {1'b0, eff_count}) begin
				adv.stop_index = idx_inc;
				adv.next_stop  = tse_pkg::stop_val(cfg, idx_inc);
			end else if (base.stop_index == '0) begin
				adv.next_stop = tse_pkg::sat_add(base.next_stop,
					tse_pkg::stop_val(cfg, '0));
			end else begin
				adv.next_stop = tse_pkg::sat_add(base.next_stop, tse_pkg::col_t'(1));
			end
		end

		run_full = adv.next_stop - adv.column;
		if (run_full > tse_pkg::col_t'(tse_pkg::RUN_MAX)) begin
			run = tse_pkg::RUN_MAX;
		end else begin
			run = run_full[tse_pkg::COUNT_BITS-1:0];
		end

		state_nxt          = adv;
		result.has_result  = 1'b1;
		result.out_char    = in_char;
		result.out_count   = tse_pkg::COUNT_BITS'(1);
		priority if (in_char == tse_pkg::CHAR_NEWLINE) begin
			state_nxt = restart_st;
		end else if (in_char == tse_pkg::CHAR_TAB) begin
			if (adv.column >= adv.next_stop) begin
				result.has_result = 1'b0;
			end else begin
				result.out_char  = tse_pkg::CHAR_SPACE;
				result.out_count = run;
				state_nxt.column = tse_pkg::sat_add(adv.column, tse_pkg::col_t'(run));
			end
		end else begin
			state_nxt.column = tse_pkg::sat_add(adv.column, tse_pkg::col_t'(1));
		end
	end

endmodule

/* dv/tse_expansion_checker.sv */
`timescale 1ns / 1ps
module tse_expansion_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	tse_in_if                            in_ch,
	tse_out_if                           out_ch,
	input  logic                         cfg_we,
	input  tse_pkg::idx_t                cfg_index,
	input  logic [tse_pkg::CFG_BITS-1:0] cfg_data,
	output int unsigned                  fail_count,
	output int unsigned                  pending
);
	import tse_pkg::*;

	typedef struct packed {
		logic [CHAR_BITS-1:0]  ch;
		logic [COUNT_BITS-1:0] count;
	} run_t;

	idx_t                 count_reg;
	logic [STOP_BITS-1:0] stop_reg [MAX_STOPS];
	col_t                 column;
	idx_t                 stop_idx;
	col_t                 stop_col;
	run_t                 runs_due [$];
	int unsigned          errors = 0;
	int unsigned          queued = 0;

	assign fail_count = errors;
	assign pending    = queued;

	function automatic col_t col_plus(input col_t a, input int unsigned b);
		logic [COLUMN_BITS:0] total;
		total = {1'b0, a} + (COLUMN_BITS+1)'(b);
		if (total[COLUMN_BITS]) return '1;
		return total[COLUMN_BITS-1:0];
	endfunction

	function automatic col_t list_stop(input idx_t i);
		if (int'(i) >= MAX_STOPS) return '0;
		return col_t'(stop_reg[i]);
	endfunction

	task automatic restart_line();
		column   = '0;
		stop_idx = '0;
		stop_col = list_stop('0);
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	task automatic expand_byte(input logic [CHAR_BITS-1:0] ch, input logic fs);
		int lanes;
		int run;
		lanes = int'(count_reg);
		if (lanes < 1) lanes = 1;
		if (lanes > MAX_STOPS) lanes = MAX_STOPS;
		if (fs) restart_line();
		if (column >= stop_col) begin
			if (int'(stop_idx) + 1 < lanes) begin
				stop_idx = stop_idx + idx_t'(1);
				stop_col = list_stop(stop_idx);
			end else if (stop_idx == '0) begin
				stop_col = col_plus(stop_col, stop_reg[0]);
			end else begin
				stop_col = col_plus(stop_col, 1);
			end
		end
		if (ch == CHAR_NEWLINE) begin
			runs_due.push_back('{ch, COUNT_BITS'(1)});
			restart_line();
		end else if (ch == CHAR_TAB) begin
			if (column < stop_col) begin
				run = int'(stop_col - column);
				if (run > int'(RUN_MAX)) run = int'(RUN_MAX);
				column = col_plus(column, run);
				runs_due.push_back('{CHAR_SPACE, COUNT_BITS'(run)});
			end
		end else begin
			runs_due.push_back('{ch, COUNT_BITS'(1)});
			column = col_plus(column, 1);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		run_t due;
		if (!arst_n) begin
			count_reg = STOP_COUNT_RESET;
			for (int i = 0; i < MAX_STOPS; i++) stop_reg[i] = '0;
			stop_reg[0] = STOP0_RESET;
			restart_line();
			runs_due.delete();
			queued = 0;
		end else begin
			if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
				if (runs_due.size() == 0) begin
					report_mismatch("transfer with nothing due, out_char", out_ch.out_char, 0);
				end else begin
					due = runs_due.pop_front();
					if (out_ch.out_char !== due.ch)
						report_mismatch("out_char", out_ch.out_char, due.ch);
					if (out_ch.out_count !== due.count)
						report_mismatch("out_count", out_ch.out_count, due.count);
				end
			end
			if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
				expand_byte(in_ch.in_char, in_ch.file_start);
			if (cfg_we === 1'b1) begin
				if (cfg_index == REG_STOP_COUNT)
					count_reg = cfg_data[INDEX_BITS-1:0];
				else
					stop_reg[cfg_index - idx_t'(1)] = cfg_data[STOP_BITS-1:0];
			end
			queued = runs_due.size();
		end
	end

endmodule

/* dv/tb_tab_stop_expander_core.sv */
`timescale 1ns / 1ps
module tb_tab_stop_expander_core;
	import tse_pkg::*;

	localparam int   CYCLE_LIMIT   = 400000;
	localparam int   HOLD_CYCLES   = 300;
	localparam int   RANDOM_PHASES = 12;
	localparam int   PHASE_ITEMS   = 76;
	localparam int   SAT_TABS      = 260;
	localparam idx_t REG_STOP_FIRST = 3'd1;

	typedef enum int {
		PLAN_RISING,
		PLAN_SCRAMBLED,
		PLAN_INTERVAL,
		PLAN_TOP_END,
		PLAN_ZERO_COUNT
	} plan_e;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	idx_t                 cfg_index;
	logic [CFG_BITS-1:0]  cfg_data;
	int unsigned          fail_count;
	int unsigned          pending;
	int unsigned          cycle_count = 0;
	int unsigned          hold_seq = 0;
	bit                   in_idle_on = 1'b1;
	bit                   out_idle_on = 1'b1;
	logic [STOP_BITS-1:0] stop_plan [MAX_STOPS];

	tse_in_if  in_ch ();
	tse_out_if out_ch ();

	tab_stop_expander_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	tse_expansion_checker expansion_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ch      (in_ch),
		.out_ch     (out_ch),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// receiver: random stall bursts, plus a long hold-off on request
	initial begin : sink_side
		int unsigned stall_left;
		int unsigned hold_left;
		int unsigned seen_seq;
		stall_left = 0;
		hold_left  = 0;
		seen_seq   = 0;
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_seq != seen_seq) begin
				seen_seq  = hold_seq;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				out_ch.ready = 1'b0;
				hold_left--;
			end else if (stall_left > 0) begin
				out_ch.ready = 1'b0;
				stall_left--;
			end else if (out_idle_on && $urandom_range(0, 5) == 0) begin
				out_ch.ready = 1'b0;
				stall_left = $urandom_range(0, 6);
			end else begin
				out_ch.ready = 1'b1;
			end
		end
	end

	task automatic send_byte(input logic [CHAR_BITS-1:0] ch, input logic fs);
		int gap;
		gap = 0;
		if (in_idle_on && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 7);
		@(negedge clk);
		if (gap > 0) begin
			in_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.valid      = 1'b1;
		in_ch.in_char    = ch;
		in_ch.file_start = fs;
		do @(posedge clk); while (in_ch.ready !== 1'b1);
	endtask

	// stop offering, drain every due transfer, then let a tab with no output clear
	task automatic settle();
		@(negedge clk);
		in_ch.valid = 1'b0;
		wait (pending == 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input idx_t idx, input logic [CFG_BITS-1:0] val);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic program_stops(input idx_t count);
		write_reg(REG_STOP_COUNT, CFG_BITS'(count));
		for (int i = 0; i < MAX_STOPS; i++)
			write_reg(REG_STOP_FIRST + idx_t'(i), stop_plan[i]);
	endtask

	task automatic random_stops();
		plan_e plan;
		int    col;
		idx_t  count;
		plan  = plan_e'($urandom_range(0, 4));
		count = idx_t'($urandom_range(1, MAX_STOPS));
		col   = 0;
		case (plan)
			PLAN_RISING: begin
				for (int i = 0; i < MAX_STOPS; i++) begin
					col = col + $urandom_range(1, 40);
					if (col > 255) col = 255;
					stop_plan[i] = STOP_BITS'(col);
				end
			end
			PLAN_SCRAMBLED: begin
				for (int i = 0; i < MAX_STOPS; i++)
					stop_plan[i] = STOP_BITS'($urandom_range(0, 255));
			end
			PLAN_INTERVAL: begin
				count = idx_t'(1);
				stop_plan[0] = STOP_BITS'($urandom_range(1, 16));
				for (int i = 1; i < MAX_STOPS; i++)
					stop_plan[i] = STOP_BITS'($urandom_range(0, 255));
			end
			PLAN_TOP_END: begin
				count = idx_t'(MAX_STOPS);
				for (int i = 0; i < MAX_STOPS; i++)
					stop_plan[i] = STOP_BITS'(255 - (MAX_STOPS - 1 - i));
			end
			default: begin
				count = '0;
				stop_plan[0] = STOP_BITS'($urandom_range(1, 12));
				for (int i = 1; i < MAX_STOPS; i++)
					stop_plan[i] = STOP_BITS'($urandom_range(0, 255));
			end
		endcase
		program_stops(count);
	endtask

	function automatic logic [CHAR_BITS-1:0] pick_char(input int nl_pct);
		int r;
		r = $urandom_range(0, 99);
		if (r < 30) return CHAR_TAB;
		if (r < 30 + nl_pct) return CHAR_NEWLINE;
		return CHAR_BITS'($urandom_range(0, 255));
	endfunction

	initial begin : stimulus
		int nl_pct;
		arst_n           = 1'b0;
		cfg_we           = 1'b0;
		cfg_index        = '0;
		cfg_data         = '0;
		in_ch.valid      = 1'b0;
		in_ch.in_char    = '0;
		in_ch.file_start = 1'b0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		// reset stops: every 8 columns
		send_byte(CHAR_TAB, 1'b0);
		send_byte(CHAR_TAB, 1'b0);
		send_byte("a", 1'b0);
		send_byte(CHAR_TAB, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(CHAR_NEWLINE, 1'b0);
		send_byte(CHAR_TAB, 1'b1);
		send_byte("b", 1'b1);
		send_byte(CHAR_NEWLINE, 1'b1);

		// short list, run past its end, tab landing on its stop
		settle();
		stop_plan = '{8'd4, 8'd6, 8'd10, 8'd1, 8'd255, 8'd128, 8'd77};
		program_stops(idx_t'(3));
		send_byte(CHAR_TAB, 1'b0);
		send_byte(CHAR_TAB, 1'b0);
		send_byte(CHAR_TAB, 1'b0);
		send_byte(CHAR_TAB, 1'b0);
		send_byte("x", 1'b0);
		send_byte(CHAR_TAB, 1'b0);
		send_byte(CHAR_NEWLINE, 1'b0);

		// zero count with zero interval
		settle();
		stop_plan = '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
		program_stops('0);
		send_byte(CHAR_TAB, 1'b0);
		send_byte("q", 1'b0);
		send_byte(CHAR_NEWLINE, 1'b0);

		// list going backwards
		settle();
		stop_plan = '{8'd10, 8'd5, 8'd200, 8'd0, 8'd0, 8'd0, 8'd0};
		program_stops(idx_t'(3));
		send_byte(CHAR_TAB, 1'b0);
		send_byte(CHAR_TAB, 1'b0);
		send_byte(CHAR_TAB, 1'b0);
		send_byte(CHAR_NEWLINE, 1'b0);

		// long line up to column saturation
		settle();
		stop_plan = '{8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
		program_stops(idx_t'(1));
		send_byte("a", 1'b0);
		for (int n = 0; n < SAT_TABS; n++) send_byte(CHAR_TAB, 1'b0);
		send_byte("z", 1'b0);
		send_byte(CHAR_TAB, 1'b0);
		send_byte(CHAR_NEWLINE, 1'b0);

		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			if (phase >= RANDOM_PHASES - 2) begin
				in_idle_on  = 1'b0;
				out_idle_on = 1'b0;
			end
			settle();
			random_stops();
			if (phase == 1 || phase == 6) hold_seq++;
			nl_pct = $urandom_range(1, 10);
			for (int n = 0; n < PHASE_ITEMS; n++)
				send_byte(pick_char(nl_pct), logic'($urandom_range(0, 99) < 3));
		end

		settle();
		repeat (8) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

/* filelist.f */
rtl/tse_pkg.sv
rtl/tse_if.sv
rtl/tse_cfg_regs.sv
rtl/tse_step.sv
rtl/tab_stop_expander_core.sv
dv/tse_expansion_checker.sv
dv/tb_tab_stop_expander_core.sv
